@@ sv/compressor_start_warmup_control_assert.svh @@
// ----------------------------------------------------------------------------
// compressor start/warm-up control assertion macros
// wraps concurrent assertions so that synthesis sees nothing
// ----------------------------------------------------------------------------
`ifndef COMPRESSOR_START_WARMUP_CONTROL_ASSERT_SVH
`define COMPRESSOR_START_WARMUP_CONTROL_ASSERT_SVH
`ifndef SYNTHESIS
// checked at every clock edge while out of reset
`define CSWC_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cswc assertion failed");
// checked at every clock edge, reset included
`define CSWC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cswc assertion failed");
`else
`define CSWC_ASSERT(label, clk, rstn, prop)
`define CSWC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ sv/cswc_pkg.sv @@
// ----------------------------------------------------------------------------
// cswc_pkg
// shared types and constants of the compressor start/warm-up control
// ----------------------------------------------------------------------------
package cswc_pkg;

  // operating modes as reported on the result
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_WARMUP = 2'd1;
  localparam logic [1:0] MODE_RUN    = 2'd2;
  localparam logic [1:0] MODE_STOP   = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_TEMP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_FULL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_FLOOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_TICKS = 3'd5;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic signed [11:0] RST_SET_TEMP   = 12'sd40;
  localparam logic signed [10:0] RST_DELTA_LOW  = 11'sd0;
  localparam logic signed [10:0] RST_DELTA_HIGH = 11'sd50;
  localparam logic [10:0]        RST_FREQ_FULL  = 11'd1250;
  localparam logic [10:0]        RST_FREQ_FLOOR = 11'd200;
  localparam logic [15:0]        RST_WARMUP     = 16'd300;

  // serial arithmetic sizes
  localparam int unsigned MUL_W  = 11;          // multiplier bits, one per cycle
  localparam int unsigned DIV_W  = 2 * MUL_W;   // dividend bits, one per cycle
  localparam int unsigned SPAN_W = 12;          // divisor width
  localparam int unsigned CNT_W  = $clog2(DIV_W);

  typedef struct packed {
    logic              system_on;
    logic              alarm_active;
    logic signed [11:0] cabinet_temp;
  } in_item_t;

  typedef struct packed {
    logic              relay_on;
    logic              warmup_done;
    logic              warmup_done_pulse;
    logic [10:0]       frequency;
    logic signed [11:0] temp_excess;
    logic [1:0]        mode;
  } out_item_t;

endpackage

@@ sv/cswc_muldiv.sv @@
// ----------------------------------------------------------------------------
// cswc_muldiv
// bit-serial multiply (a * b) followed by restoring divide by span
// ----------------------------------------------------------------------------
`include "compressor_start_warmup_control_assert.svh"

module cswc_muldiv (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [cswc_pkg::MUL_W-1:0]      a_i,
  input  logic [cswc_pkg::MUL_W-1:0]      b_i,
  input  logic [cswc_pkg::SPAN_W-1:0]     span_i,
  output logic                            done_o,
  output logic [cswc_pkg::MUL_W-1:0]      quo_o
);

  localparam logic [cswc_pkg::CNT_W-1:0] MUL_LAST = cswc_pkg::CNT_W'(cswc_pkg::MUL_W - 1);
  localparam logic [cswc_pkg::CNT_W-1:0] DIV_LAST = cswc_pkg::CNT_W'(cswc_pkg::DIV_W - 1);

  logic                          busy_q, busy_d;
  logic                          div_q, div_d;
  logic                          done_q, done_d;
  logic [cswc_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [cswc_pkg::MUL_W-1:0]    a_q, a_d;
  logic [cswc_pkg::MUL_W-1:0]    b_q, b_d;
  logic [cswc_pkg::SPAN_W-1:0]   span_q, span_d;
  logic [cswc_pkg::DIV_W-1:0]    acc_q, acc_d;
  logic [cswc_pkg::SPAN_W-1:0]   rem_q, rem_d;
  logic [cswc_pkg::SPAN_W:0]     rem_sh;
  logic                          qbit;

  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    span_d = span_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    rem_sh = {rem_q, acc_q[cswc_pkg::DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, span_q});
    if (start_i) begin
      busy_d = 1'b1;
      div_d  = 1'b0;
      cnt_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      span_d = span_i;
      acc_d  = '0;
      rem_d  = '0;
    end else if (busy_q && !div_q) begin
      // multiplier msb first: acc = 2*acc + bit*a
      acc_d = {acc_q[cswc_pkg::DIV_W-2:0], 1'b0}
            + (b_q[cswc_pkg::MUL_W-1] ? cswc_pkg::DIV_W'(a_q) : '0);
      b_d   = {b_q[cswc_pkg::MUL_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MUL_LAST) begin
        div_d = 1'b1;
        cnt_d = '0;
      end
    end else if (busy_q) begin
      // one quotient bit per cycle, shifted into the dividend register
      rem_d = qbit ? cswc_pkg::SPAN_W'(rem_sh - {1'b0, span_q})
                   : rem_sh[cswc_pkg::SPAN_W-1:0];
      acc_d = {acc_q[cswc_pkg::DIV_W-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    span_q <= span_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = acc_q[cswc_pkg::MUL_W-1:0];

  `CSWC_ASSERT(a_md_no_restart, clk_i, rst_ni, start_i |-> !busy_q)
  `CSWC_ASSERT(a_md_done_single, clk_i, rst_ni, done_q |=> !done_q)
  `CSWC_ASSERT(a_md_quo_fits, clk_i, rst_ni,
    done_q |-> (acc_q[cswc_pkg::DIV_W-1:cswc_pkg::MUL_W] == '0))

endmodule

@@ sv/compressor_start_warmup_control.sv @@
// ----------------------------------------------------------------------------
// compressor_start_warmup_control
// start, warm-up and run control of a compressor with frequency interpolation
// ----------------------------------------------------------------------------
// usage:
//   input channel carries one control tick per transaction (system_on,
//   alarm_active, cabinet_temp); output channel returns exactly one result
//   transaction per tick with relay, warm-up flags, frequency, excess and mode.
//   both channels: transaction at a clock edge with valid high and stall low.
//   configuration is a plain write port (index, data), to be written only when
//   idle by the user; the block itself does not enforce this.
// sequencing: a tick that needs no interpolation goes straight to the done
//   phase; a running tick between the two thresholds first passes the calc
//   phase, where the muldiv unit runs a serial multiply, then a restoring
//   divide. one tick is worked on at a time: the input stalls until its
//   result has moved into the output register.
// reset: mode idle, relay off, counters and stored frequency/excess zero,
//   registers at their documented defaults, output channel empty.
// output stall: a finished result sits in the output register; the next tick
//   is already taken while it waits, and its result is held back until the
//   output register frees.
// ----------------------------------------------------------------------------
`include "compressor_start_warmup_control_assert.svh"

module compressor_start_warmup_control (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tick input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  cswc_pkg::in_item_t                 in_data_i,
  // result output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output cswc_pkg::out_item_t                out_data_o,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [cswc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cswc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  // control phases
  localparam logic [1:0] PH_IDLE = 2'd0;  // ready for a tick
  localparam logic [1:0] PH_CALC = 2'd1;  // interpolation running
  localparam logic [1:0] PH_DONE = 2'd2;  // result ready for the output register

  // configuration registers
  logic signed [11:0] set_temp_q;
  logic signed [10:0] dlow_q;
  logic signed [10:0] dhigh_q;
  logic [10:0]        ffull_q;
  logic [10:0]        ffloor_q;
  logic [15:0]        wticks_q;

  // control state
  logic [1:0]         phase_q, phase_d;
  logic [1:0]         mode_q, mode_d;
  logic [15:0]        wcnt_q, wcnt_d;
  logic [10:0]        freq_q, freq_d;
  logic signed [11:0] excess_q, excess_d;
  logic               relay_q, relay_d;
  logic               warm_q, warm_d;
  logic               pulse_q, pulse_d;
  logic               neg_q, neg_d;

  // output register
  logic               out_valid_q, out_valid_d;
  cswc_pkg::out_item_t out_q, out_d;

  // datapath
  logic               in_accept;
  logic               out_free;
  logic signed [12:0] diff;          // cabinet minus set, exact
  logic               ge_high;
  logic               le_low;
  logic signed [12:0] over_low;      // excess above delta_low
  logic signed [11:0] span;
  logic signed [11:0] fdiff;         // full minus floor
  logic [10:0]        fmag;
  logic [15:0]        wcnt_inc;
  logic               md_start;
  logic               md_done;
  logic [10:0]        md_quo;
  logic signed [11:0] qsigned;
  logic signed [11:0] fnew;

  assign in_stall_o = (phase_q != PH_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_temp_q <= cswc_pkg::RST_SET_TEMP;
      dlow_q     <= cswc_pkg::RST_DELTA_LOW;
      dhigh_q    <= cswc_pkg::RST_DELTA_HIGH;
      ffull_q    <= cswc_pkg::RST_FREQ_FULL;
      ffloor_q   <= cswc_pkg::RST_FREQ_FLOOR;
      wticks_q   <= cswc_pkg::RST_WARMUP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cswc_pkg::CFG_SET_TEMP:     set_temp_q <= cfg_wdata_i[11:0];
        cswc_pkg::CFG_DELTA_LOW:    dlow_q     <= cfg_wdata_i[10:0];
        cswc_pkg::CFG_DELTA_HIGH:   dhigh_q    <= cfg_wdata_i[10:0];
        cswc_pkg::CFG_FREQ_FULL:    ffull_q    <= cfg_wdata_i[10:0];
        cswc_pkg::CFG_FREQ_FLOOR:   ffloor_q   <= cfg_wdata_i[10:0];
        cswc_pkg::CFG_WARMUP_TICKS: wticks_q   <= cfg_wdata_i;
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // regulation datapath, evaluated on the accepted tick
  // ---------------------------------------------------------------------------
  assign diff     = 13'(in_data_i.cabinet_temp) - 13'(set_temp_q);
  assign ge_high  = (diff >= 13'(dhigh_q));
  assign le_low   = (diff <= 13'(dlow_q));
  assign over_low = diff - 13'(dlow_q);
  assign span     = 12'(dhigh_q) - 12'(dlow_q);
  assign fdiff    = $signed({1'b0, ffull_q}) - $signed({1'b0, ffloor_q});
  assign fmag     = fdiff[11] ? 11'(-fdiff) : fdiff[10:0];
  assign wcnt_inc = (wcnt_q == 16'hFFFF) ? wcnt_q : wcnt_q + 16'd1;

  // quotient carries the sign of full minus floor (truncation toward zero)
  assign qsigned = neg_q ? -$signed({1'b0, md_quo}) : $signed({1'b0, md_quo});
  assign fnew    = $signed({1'b0, ffloor_q}) + qsigned;

  // ---------------------------------------------------------------------------
  // mode machine and result sequencing
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d     = phase_q;
    mode_d      = mode_q;
    wcnt_d      = wcnt_q;
    freq_d      = freq_q;
    excess_d    = excess_q;
    relay_d     = relay_q;
    warm_d      = warm_q;
    pulse_d     = pulse_q;
    neg_d       = neg_q;
    md_start    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (phase_q)
      PH_IDLE: begin
        if (in_accept) begin
          pulse_d = 1'b0;
          phase_d = PH_DONE;
          unique case (mode_q)
            cswc_pkg::MODE_IDLE: begin
              if (in_data_i.system_on && !in_data_i.alarm_active) begin
                mode_d  = cswc_pkg::MODE_WARMUP;
                wcnt_d  = '0;
                relay_d = 1'b1;
                warm_d  = 1'b0;
                freq_d  = ffull_q;
              end
            end
            cswc_pkg::MODE_WARMUP: begin
              if (in_data_i.alarm_active) begin
                relay_d = 1'b0;
                mode_d  = cswc_pkg::MODE_STOP;
              end else begin
                wcnt_d = wcnt_inc;
                if (wcnt_inc >= wticks_q) begin
                  warm_d  = 1'b1;
                  pulse_d = 1'b1;
                  mode_d  = cswc_pkg::MODE_RUN;
                end
              end
            end
            cswc_pkg::MODE_RUN: begin
              if (in_data_i.alarm_active || !in_data_i.system_on) begin
                relay_d = 1'b0;
                mode_d  = cswc_pkg::MODE_STOP;
              end else begin
                // reported excess saturates to twelve bits
                if (diff[12] != diff[11]) begin
                  excess_d = diff[12] ? 12'sh800 : 12'sh7FF;
                end else begin
                  excess_d = diff[11:0];
                end
                if (ge_high) begin
                  freq_d = ffull_q;
                end else if (le_low) begin
                  freq_d = ffloor_q;
                end else begin
                  // strictly between thresholds: interpolate serially
                  neg_d    = fdiff[11];
                  md_start = 1'b1;
                  phase_d  = PH_CALC;
                end
              end
            end
            default: begin
              // stopped: hold outputs off until the alarm clears
              relay_d = 1'b0;
              warm_d  = 1'b0;
              if (!in_data_i.alarm_active) begin
                mode_d = cswc_pkg::MODE_IDLE;
              end
            end
          endcase
        end
      end
      PH_CALC: begin
        if (md_done) begin
          freq_d  = fnew[10:0];
          phase_d = PH_DONE;
        end
      end
      PH_DONE: begin
        if (out_free) begin
          out_valid_d                 = 1'b1;
          out_d.relay_on              = relay_q;
          out_d.warmup_done           = warm_q;
          out_d.warmup_done_pulse     = pulse_q;
          out_d.frequency             = freq_q;
          out_d.temp_excess           = excess_q;
          out_d.mode                  = mode_q;
          phase_d                     = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      mode_q      <= cswc_pkg::MODE_IDLE;
      wcnt_q      <= '0;
      freq_q      <= '0;
      excess_q    <= '0;
      relay_q     <= 1'b0;
      warm_q      <= 1'b0;
      pulse_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      mode_q      <= mode_d;
      wcnt_q      <= wcnt_d;
      freq_q      <= freq_d;
      excess_q    <= excess_d;
      relay_q     <= relay_d;
      warm_q      <= warm_d;
      pulse_q     <= pulse_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload only
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    out_q <= out_d;
  end

  // serial multiply/divide unit: |full - floor| * (excess - delta_low) / span
  cswc_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(md_start),
    .a_i    (fmag),
    .b_i    (over_low[10:0]),
    .span_i (span),
    .done_o (md_done),
    .quo_o  (md_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CSWC_ASSERT(a_relay_mode, clk_i, rst_ni,
    relay_q |-> (mode_q == cswc_pkg::MODE_WARMUP || mode_q == cswc_pkg::MODE_RUN))
  `CSWC_ASSERT(a_calc_in_run, clk_i, rst_ni,
    (phase_q == PH_CALC) |-> (mode_q == cswc_pkg::MODE_RUN))
  `CSWC_ASSERT(a_done_in_calc, clk_i, rst_ni, md_done |-> (phase_q == PH_CALC))
  `CSWC_ASSERT_ALWAYS(a_pulse_run, clk_i,
    (out_valid_q && out_q.warmup_done_pulse) |->
      (out_q.mode == cswc_pkg::MODE_RUN && out_q.warmup_done))

endmodule
